// ===== rtl/core/fgmn_pkg.sv =====
// Package for the forward-gradient min/max normalize unit.
// Types and constants shared by the top level and its checker; no dependencies.
package fgmn_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned AddrW     = ColW + RowW;

  localparam logic [1:0] OpLoad    = 2'd0;
  localparam logic [1:0] OpCompute = 2'd1;
  localparam logic [1:0] OpRead    = 2'd2;
  localparam logic [1:0] OpUnused  = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFlat    = 2'd1;
  localparam logic [1:0] StOutside = 2'd2;
  localparam logic [1:0] StNoRange = 2'd3;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] grad_x;
    logic [7:0] grad_y;
    logic [1:0] status;
  } out_item_t;

endpackage

// ===== rtl/core/forward_gradient_minmax_normalize_unit.sv =====
// Top level: pixel store, compute walk, normalizing read with serial divider.
// Depends on fgmn_pkg.
//
//  channel | direction | handshake          | payload
//  in      | to unit   | in_valid_i/in_stall_o   | fgmn_pkg::in_item_t
//  out     | from unit | out_valid_o/out_stall_i | fgmn_pkg::out_item_t
//  cfg     | to unit   | cfg_valid_i/cfg_ready_o | index, 9-bit data
//
// Loads, reads outside the image or before compute, and the unused op give
// their result through the decode state and the output state. A read in range
// does the three store reads, then four passes of a 16-step restoring divider,
// then loads the output. Compute walks each position that has a right and a
// below neighbour through the read states SRdB to SRdE. One item at a time;
// the next is taken once the result is in the output register, and is held off
// while that result is stalled. Reset clears control and min/max; the store is not cleared.
module forward_gradient_minmax_normalize_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fgmn_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fgmn_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [8:0]           cfg_data_i
);
  import fgmn_pkg::*;

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SRdA  = 4'd1;  // decode item
  localparam logic [3:0] SRdB  = 4'd2;  // issue read of here
  localparam logic [3:0] SRdC  = 4'd3;  // issue read of right, here lands
  localparam logic [3:0] SRdD  = 4'd4;  // issue read of below, right lands
  localparam logic [3:0] SDiv  = 4'd5;
  localparam logic [3:0] SOut  = 4'd6;
  localparam logic [3:0] SRdE  = 4'd7;  // below lands

  logic [3:0] state_q;
  logic [8:0] width_q, height_q;
  logic       ready_q;
  logic [7:0] minh_q, maxh_q, minv_q, maxv_q;
  logic       first_q;
  in_item_t   item_q;
  logic [ColW-1:0] c_q;
  logic [RowW-1:0] r_q;
  logic [7:0] here_q, dx_q, dy_q;
  out_item_t  res_q;
  logic       res_valid_q;

  // store
  logic [7:0] mem [2**AddrW];
  logic [7:0] rdata_q;
  logic            we;
  logic [AddrW-1:0] waddr, raddr;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= item_q.pixel;
    rdata_q <= mem[raddr];
  end

  // clamped dims
  logic [8:0] w, h;
  always_comb begin
    w = (width_q < 9'd2) ? 9'd2 : (width_q > 9'(MaxWidth) ? 9'(MaxWidth) : width_q);
    h = (height_q < 9'd2) ? 9'd2 : (height_q > 9'(MaxHeight) ? 9'(MaxHeight) : height_q);
  end

  logic outside;
  assign outside = ({1'b0, item_q.col} >= w) || ({1'b0, item_q.row} >= h);

  logic [8:0] c_last, r_last;
  assign c_last = w - 9'd2;
  assign r_last = h - 9'd2;

  // status decided at decode
  logic [1:0] st_first;
  always_comb begin
    st_first = StOk;
    if ((item_q.op == OpLoad || item_q.op == OpRead) && outside) st_first = StOutside;
    else if (item_q.op == OpRead && !ready_q) st_first = StNoRange;
  end

  // divider: quotient of 255*num / den, 16 steps
  logic [15:0] dnum_q;
  logic [16:0] drem_q;
  logic [7:0]  dden_q;
  logic [4:0]  dcnt_q;
  logic [1:0]  dsel_q;   // 0 dx,1 minh,2 dy,3 minv
  logic [15:0] q0_q, q1_q, q2_q;
  logic [16:0] rem_sh, rem_sub;
  assign rem_sh  = {drem_q[15:0], dnum_q[15]};
  assign rem_sub = rem_sh - {9'd0, dden_q};

  logic [7:0] dh, dv;
  assign dh = maxh_q - minh_q;
  assign dv = maxv_q - minv_q;

  function automatic logic [15:0] times255(input logic [7:0] v);
    times255 = {v, 8'd0} - {8'd0, v};
  endfunction

  logic [7:0] ad_right, ad_below;
  always_comb begin
    ad_right = (rdata_q > here_q) ? rdata_q - here_q : here_q - rdata_q;
    ad_below = ad_right;
  end

  function automatic logic [7:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (s[16]) sat_sub = 8'd0;
    else if (s[15:0] > 16'd255) sat_sub = 8'd255;
    else sat_sub = s[7:0];
  endfunction

  logic accept_in, accept_out, out_load;
  assign in_stall_o  = (state_q != SIdle) || (res_valid_q && out_stall_i);
  assign accept_in   = in_valid_i && !in_stall_o;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;
  assign accept_out  = res_valid_q && !out_stall_i;
  assign out_load    = (state_q == SOut) && (!res_valid_q || accept_out);
  assign cfg_ready_o = (state_q == SIdle);

  // read address
  logic [ColW-1:0] ca;
  logic [RowW-1:0] ra;
  always_comb begin
    raddr = {r_q, c_q};
    unique case (state_q)
      SRdC:    raddr = {r_q, c_q + ColW'(1)};
      SRdD:    raddr = {r_q + RowW'(1), c_q};
      default: raddr = {r_q, c_q};
    endcase
    ca = c_q; ra = r_q;
    waddr = {item_q.row, item_q.col};
  end

  logic [7:0] nminh, nmaxh, nminv, nmaxv;
  always_comb begin
    nminh = first_q || (dx_q < minh_q) ? dx_q : minh_q;
    nmaxh = first_q || (dx_q > maxh_q) ? dx_q : maxh_q;
    nminv = first_q || (ad_below < minv_q) ? ad_below : minv_q;
    nmaxv = first_q || (ad_below > maxv_q) ? ad_below : maxv_q;
  end

  logic walk_end;
  assign walk_end = ({1'b0, ca} == c_last) && ({1'b0, ra} == r_last);

  assign we = (state_q == SRdA) && (item_q.op == OpLoad) && !outside;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      width_q     <= 9'd256;
      height_q    <= 9'd256;
      ready_q     <= 1'b0;
      minh_q      <= '0;
      maxh_q      <= '0;
      minv_q      <= '0;
      maxv_q      <= '0;
      res_valid_q <= 1'b0;
      first_q     <= 1'b0;
      item_q      <= '0;
      c_q         <= '0;
      r_q         <= '0;
      here_q      <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      res_q       <= '0;
      dnum_q      <= '0;
      drem_q      <= '0;
      dden_q      <= '0;
      dcnt_q      <= '0;
      dsel_q      <= '0;
      q0_q        <= '0;
      q1_q        <= '0;
      q2_q        <= '0;
    end else begin
      if (out_load) res_valid_q <= 1'b1;
      else if (accept_out) res_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegWidth) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
        ready_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: if (accept_in) begin
          item_q  <= in_data_i;
          state_q <= SRdA;
        end
        SRdA: begin
          res_q <= '{grad_x: 8'd0, grad_y: 8'd0, status: st_first};
          if (item_q.op == OpLoad) begin
            if (!outside) ready_q <= 1'b0;
            state_q <= SOut;
          end else if (item_q.op == OpRead) begin
            if (outside || !ready_q) begin
              state_q <= SOut;
            end else begin
              c_q <= ({1'b0, item_q.col} == w - 9'd1) ? c_last[ColW-1:0] : item_q.col;
              r_q <= ({1'b0, item_q.row} == h - 9'd1) ? r_last[RowW-1:0] : item_q.row;
              state_q <= SRdB;
            end
          end else if (item_q.op == OpCompute) begin
            c_q <= '0; r_q <= '0; first_q <= 1'b1;
            state_q <= SRdB;
          end else begin
            state_q <= SOut;
          end
        end
        SRdB: state_q <= SRdC;
        SRdC: begin
          here_q  <= rdata_q;
          state_q <= SRdD;
        end
        SRdD: begin
          dx_q    <= ad_right;
          state_q <= SRdE;
        end
        SRdE: begin
          if (item_q.op == OpCompute) begin
            minh_q <= nminh; maxh_q <= nmaxh;
            minv_q <= nminv; maxv_q <= nmaxv;
            first_q <= 1'b0;
            if (walk_end) begin
              ready_q <= 1'b1;
              res_q.status <= ((nminh == nmaxh) || (nminv == nmaxv)) ? StFlat : StOk;
              state_q <= SOut;
            end else begin
              if ({1'b0, c_q} == c_last) begin
                c_q <= '0; r_q <= r_q + RowW'(1);
              end else c_q <= c_q + ColW'(1);
              state_q <= SRdB;
            end
          end else begin
            dy_q    <= ad_below;
            dsel_q  <= 2'd0;
            dnum_q  <= times255(dx_q);
            dden_q  <= dh;
            drem_q  <= '0;
            dcnt_q  <= '0;
            state_q <= SDiv;
          end
        end
        SDiv: begin
          if (dcnt_q == 5'd16) begin
            dcnt_q <= '0;
            drem_q <= '0;
            unique case (dsel_q)
              2'd0: begin q0_q <= dnum_q; dnum_q <= times255(minh_q); end
              2'd1: begin q1_q <= dnum_q; dnum_q <= times255(dy_q); dden_q <= dv; end
              2'd2: begin q2_q <= dnum_q; dnum_q <= times255(minv_q); end
              default: begin
                res_q <= '{grad_x: (dh == 8'd0) ? 8'd0 : sat_sub(q0_q, q1_q),
                           grad_y: (dv == 8'd0) ? 8'd0 : sat_sub(q2_q, dnum_q),
                           status: ((dh == 8'd0) || (dv == 8'd0)) ? StFlat : StOk};
                state_q <= SOut;
              end
            endcase
            dsel_q <= dsel_q + 2'd1;
          end else begin
            dcnt_q <= dcnt_q + 5'd1;
            if (!rem_sub[16] && dden_q != 8'd0) begin
              drem_q <= rem_sub;
              dnum_q <= {dnum_q[14:0], 1'b1};
            end else begin
              drem_q <= rem_sh;
              dnum_q <= {dnum_q[14:0], 1'b0};
            end
          end
        end
        SOut: if (out_load) begin
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

// ===== rtl/core/fgmn_checker.sv =====
// Port checker for the forward-gradient unit, bound to the top level.
// Depends on fgmn_pkg.
module fgmn_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fgmn_pkg::out_item_t out_data_o,
  input logic                cfg_ready_o
);
  import fgmn_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_no_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !cfg_ready_o)
    else $error("config open while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken at once");

  a_grad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StOutside || out_data_o.status == StNoRange)
    |-> out_data_o.grad_x == 8'd0 && out_data_o.grad_y == 8'd0)
    else $error("nonzero gradient with error status");
endmodule

bind forward_gradient_minmax_normalize_unit fgmn_checker u_fgmn_checker (.*);
